// File: hdl/ssib_pkg.sv
// Shared constants, codes and types of the string stack block.
// Used by every other file of the block but ssib_ram; depends on nothing.
package ssib_pkg;

    // Sizing of the byte store and of the records kept in it
    localparam int BUF_BYTES  = 4096;
    localparam int LINK_BYTES = 2;
    localparam int MAX_LEN    = 63;

    // Derived widths
    localparam int ADDR_W     = $clog2(BUF_BYTES);
    localparam int PTR_W      = ADDR_W + 1;
    localparam int SIZE_W     = 13;
    localparam int CALC_W     = ((SIZE_W > PTR_W) ? SIZE_W : PTR_W) + 1;
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int LINK_CNT_W = $clog2(LINK_BYTES + 1);
    localparam int CHAR_W     = 8;
    localparam int CMD_W      = 2;
    localparam int STATUS_W   = 2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(4096);

    // Request queue between front and back
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // Command codes on the request channel
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POP   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Status codes on the result channel
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

    // Classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_PUSH_CHAR,
        OP_PUSH_END,
        OP_POP,
        OP_CLEAR
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        logic [CHAR_W-1:0] ch;
    } op_t;

    typedef struct packed {
        logic valid;
        op_t  op;
    } head_t;

    // Back-end sequencer states
    typedef enum logic [7:0] {
        ST_IDLE      = 8'b0000_0001,
        ST_PUSH_LINK = 8'b0000_0010,
        ST_RESULT    = 8'b0000_0100,
        ST_POP_RD    = 8'b0000_1000,
        ST_POP_CHK   = 8'b0001_0000,
        ST_POP_TERM  = 8'b0010_0000,
        ST_LINK_RD   = 8'b0100_0000,
        ST_LINK_CHK  = 8'b1000_0000
    } state_t;

endpackage

// File: hdl/ssib_req_if.sv
// Request channel: valid/ready handshake carrying a command and a character.
// Depends on ssib_pkg for field widths.
interface ssib_req_if;
    logic                          valid;
    logic                          ready;
    logic [ssib_pkg::CMD_W-1:0]    cmd;
    logic [ssib_pkg::CHAR_W-1:0]   char_in;

    modport source (output valid, output cmd, output char_in, input ready);
    modport sink   (input valid, input cmd, input char_in, output ready);
endinterface

// File: hdl/ssib_rsp_if.sv
// Result channel: valid/ready handshake carrying a character, last and status.
// Depends on ssib_pkg for field widths.
interface ssib_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ssib_pkg::CHAR_W-1:0]   char_out;
    logic                          last;
    logic [ssib_pkg::STATUS_W-1:0] status;

    modport source (output valid, output char_out, output last, output status, input ready);
    modport sink   (input valid, input char_out, input last, input status, output ready);
endinterface

// File: hdl/ssib_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module ssib_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/ssib_front.sv
// Front end: accepts requests, classifies them and queues them for the back end.
// Depends on ssib_pkg and ssib_req_if.
module ssib_front (
    input  logic               clk,
    input  logic               rst_n,
    ssib_req_if.sink           requests,
    output ssib_pkg::head_t    head,
    input  logic               q_pop
);
    import ssib_pkg::*;

    op_t               q_mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    op_t               op_new;
    logic              keep;
    logic              q_push;
    logic              do_pop;

    // Classify the incoming request; the unused command code is dropped
    always_comb
    begin
        keep         = requests.cmd inside {CMD_PUSH, CMD_POP, CMD_CLEAR};
        op_new.ch    = requests.char_in;
        op_new.kind  = OP_CLEAR;
        case (requests.cmd)
            CMD_PUSH:  op_new.kind = (requests.char_in == '0) ? OP_PUSH_END : OP_PUSH_CHAR;
            CMD_POP:   op_new.kind = OP_POP;
            CMD_CLEAR: op_new.kind = OP_CLEAR;
            default:   op_new.kind = OP_CLEAR;
        endcase
    end

    assign requests.ready = (count_reg != QCNT_W'(QDEPTH));
    assign q_push         = requests.valid && requests.ready && keep;
    assign do_pop         = q_pop && (count_reg != '0);

    // Advance queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = q_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(q_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem[wr_ptr_reg] <= op_new;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.op    = q_mem[rd_ptr_reg];

endmodule

// File: hdl/ssib_back.sv
// Back end: carries out queued operations on the byte store and emits results.
// Depends on ssib_pkg, ssib_rsp_if and ssib_ram.
module ssib_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ssib_pkg::head_t              head,
    output logic                         q_pop,
    input  logic                         buffer_size_we,
    input  logic [ssib_pkg::SIZE_W-1:0]  buffer_size,
    ssib_rsp_if.source                   results
);
    import ssib_pkg::*;

    state_t                state_reg, state_next;
    logic [SIZE_W-1:0]     size_reg, size_next;
    logic [PTR_W-1:0]      top_reg, top_next;
    logic [ADDR_W-1:0]     newest_reg, newest_next;
    logic                  has_reg, has_next;
    logic [LEN_W-1:0]      pend_len_reg, pend_len_next;
    logic                  pend_ovf_reg, pend_ovf_next;
    logic                  out_valid_reg, out_valid_next;

    logic [PTR_W-1:0]      addr_reg, addr_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LINK_CNT_W-1:0] link_cnt_reg, link_cnt_next;
    logic [ADDR_W-1:0]     link_sh_reg, link_sh_next;
    logic [PTR_W-1:0]      need_reg, need_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [CHAR_W-1:0]     out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;

    logic [CALC_W-1:0]     size_eff;
    logic [CALC_W-1:0]     pos;
    logic [CALC_W-1:0]     need;
    logic                  out_free;
    logic                  out_load;
    logic                  link_done;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [CHAR_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [CHAR_W-1:0]     ram_rdata;

    ssib_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (BUF_BYTES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Usable size, write position of the pending string and record end
    assign size_eff  = (CALC_W'(size_reg) < CALC_W'(BUF_BYTES)) ? CALC_W'(size_reg)
                                                                 : CALC_W'(BUF_BYTES);
    assign pos       = CALC_W'(top_reg) + CALC_W'(pend_len_reg);
    assign need      = pos + CALC_W'(1 + LINK_BYTES);
    assign out_free  = !out_valid_reg || results.ready;
    assign link_done = (link_cnt_reg == LINK_CNT_W'(LINK_BYTES - 1));

    // Sequence one operation at a time
    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        top_next        = top_reg;
        newest_next     = newest_reg;
        has_next        = has_reg;
        pend_len_next   = pend_len_reg;
        pend_ovf_next   = pend_ovf_reg;
        addr_next       = addr_reg;
        len_next        = len_reg;
        link_cnt_next   = link_cnt_reg;
        link_sh_next    = link_sh_reg;
        need_next       = need_reg;
        status_next     = status_reg;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        out_load        = 1'b0;
        q_pop           = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = pos[ADDR_W-1:0];
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = addr_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    q_pop = 1'b1;
                    case (head.op.kind)
                        OP_PUSH_CHAR:
                        begin
                            if (pend_len_reg >= LEN_W'(MAX_LEN))
                            begin
                                pend_ovf_next = 1'b1;
                            end
                            else
                            begin
                                // store only what lies inside the usable size
                                if (pos < size_eff)
                                begin
                                    ram_we    = 1'b1;
                                    ram_wdata = head.op.ch;
                                end
                                pend_len_next = pend_len_reg + 1'b1;
                            end
                        end
                        OP_PUSH_END:
                        begin
                            pend_len_next = '0;
                            pend_ovf_next = 1'b0;
                            if (!pend_ovf_reg && (need <= size_eff))
                            begin
                                // write terminator, then the link bytes
                                ram_we        = 1'b1;
                                ram_wdata     = '0;
                                addr_next     = PTR_W'(pos) + 1'b1;
                                link_cnt_next = '0;
                                link_sh_next  = newest_reg;
                                need_next     = PTR_W'(need);
                                state_next    = ST_PUSH_LINK;
                            end
                            else
                            begin
                                status_next = STATUS_OVERFLOW;
                                state_next  = ST_RESULT;
                            end
                        end
                        OP_POP:
                        begin
                            pend_len_next = '0;
                            pend_ovf_next = 1'b0;
                            if (!has_reg)
                            begin
                                status_next = STATUS_EMPTY;
                                state_next  = ST_RESULT;
                            end
                            else
                            begin
                                addr_next  = PTR_W'(newest_reg);
                                len_next   = '0;
                                state_next = ST_POP_RD;
                            end
                        end
                        OP_CLEAR:
                        begin
                            top_next      = '0;
                            newest_next   = '0;
                            has_next      = 1'b0;
                            pend_len_next = '0;
                            pend_ovf_next = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_PUSH_LINK:
            begin
                // write the previous start, low byte first
                ram_we        = 1'b1;
                ram_waddr     = addr_reg[ADDR_W-1:0];
                ram_wdata     = link_sh_reg[CHAR_W-1:0];
                link_sh_next  = link_sh_reg >> CHAR_W;
                addr_next     = addr_reg + 1'b1;
                link_cnt_next = link_cnt_reg + 1'b1;
                if (link_done)
                begin
                    newest_next = top_reg[ADDR_W-1:0];
                    has_next    = 1'b1;
                    top_next    = need_reg;
                    status_next = STATUS_OK;
                    state_next  = ST_RESULT;
                end
            end

            ST_RESULT:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_char_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = status_reg;
                    state_next      = ST_IDLE;
                end
            end

            ST_POP_RD:
            begin
                if (len_reg == LEN_W'(MAX_LEN))
                begin
                    state_next = ST_POP_TERM;
                end
                else
                begin
                    ram_re     = 1'b1;
                    state_next = ST_POP_CHK;
                end
            end

            ST_POP_CHK:
            begin
                if (ram_rdata == '0)
                begin
                    state_next = ST_POP_TERM;
                end
                else if (out_free)
                begin
                    out_load        = 1'b1;
                    out_char_next   = ram_rdata;
                    out_last_next   = 1'b0;
                    out_status_next = STATUS_OK;
                    len_next        = len_reg + 1'b1;
                    addr_next       = addr_reg + 1'b1;
                    state_next      = ST_POP_RD;
                end
            end

            ST_POP_TERM:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_char_next   = '0;
                    out_last_next   = 1'b1;
                    out_status_next = STATUS_OK;
                    // read the link from its highest byte down
                    addr_next       = addr_reg + PTR_W'(LINK_BYTES);
                    link_cnt_next   = '0;
                    link_sh_next    = '0;
                    state_next      = ST_LINK_RD;
                end
            end

            ST_LINK_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_LINK_CHK;
            end

            ST_LINK_CHK:
            begin
                link_sh_next  = ADDR_W'({link_sh_reg, ram_rdata});
                addr_next     = addr_reg - 1'b1;
                link_cnt_next = link_cnt_reg + 1'b1;
                if (link_done)
                begin
                    top_next    = PTR_W'(newest_reg);
                    has_next    = (newest_reg != '0);
                    newest_next = (newest_reg != '0) ? ADDR_W'({link_sh_reg, ram_rdata}) : '0;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    state_next = ST_LINK_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Size write empties the stack
        if (buffer_size_we)
        begin
            size_next     = buffer_size;
            top_next      = '0;
            newest_next   = '0;
            has_next      = 1'b0;
            pend_len_next = '0;
            pend_ovf_next = 1'b0;
        end

        // Hold or drop the output register
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= SIZE_RESET;
            top_reg       <= '0;
            newest_reg    <= '0;
            has_reg       <= 1'b0;
            pend_len_reg  <= '0;
            pend_ovf_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            top_reg       <= top_next;
            newest_reg    <= newest_next;
            has_reg       <= has_next;
            pend_len_reg  <= pend_len_next;
            pend_ovf_reg  <= pend_ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        len_reg        <= len_next;
        link_cnt_reg   <= link_cnt_next;
        link_sh_reg    <= link_sh_next;
        need_reg       <= need_next;
        status_reg     <= status_next;
        out_char_reg   <= out_char_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    assign results.valid    = out_valid_reg;
    assign results.char_out = out_char_reg;
    assign results.last     = out_last_reg;
    assign results.status   = out_status_reg;

endmodule

// File: hdl/string_stack_in_buffer_core.sv
// Top level of the string stack: front end, request queue and back end.
// Depends on ssib_pkg, ssib_req_if, ssib_rsp_if, ssib_front and ssib_back.
//
//  channel         direction  fields                      request moves
//  requests        in         cmd, char_in                push char / pop / clear
//  results         out        char_out, last, status      one popped char or status
//  buffer_size_we  in         buffer_size                 size write, stack emptied
//
// The front end takes a request in every cycle while its 4-entry queue has room.
// The back end carries out one queued request at a time: a pushed character goes to
// the byte store; a push end writes the terminator and the LINK_BYTES link bytes when
// committed and reports overflow when rolled back; a pop reads its characters and then
// its link through the single read port of the byte store; an empty pop reports empty.
// Reset clears the stack and queue pointers; the byte store is not cleared.
// A stalled result holds in the output register while the queue keeps filling.
module string_stack_in_buffer_core (
    input  logic                         clk,
    input  logic                         rst_n,
    ssib_req_if.sink                     requests,
    ssib_rsp_if.source                   results,
    input  logic                         buffer_size_we,
    input  logic [ssib_pkg::SIZE_W-1:0]  buffer_size
);
    import ssib_pkg::*;

    head_t head;
    logic  q_pop;

    ssib_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .requests (requests),
        .head     (head),
        .q_pop    (q_pop)
    );

    ssib_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .q_pop          (q_pop),
        .buffer_size_we (buffer_size_we),
        .buffer_size    (buffer_size),
        .results        (results)
    );

endmodule

// File: hdl/ssib_checker.sv
// Port-level checks on the string stack results, bound to the top level.
// Depends on ssib_pkg and string_stack_in_buffer_core.
module ssib_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic [ssib_pkg::CHAR_W-1:0]    char_out,
    input  logic                           last,
    input  logic [ssib_pkg::STATUS_W-1:0]  status
);
    import ssib_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(char_out) && $stable(last)
                                    && $stable(status))
        else $error("stalled result changed");

    // Only known status codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK) || (status == STATUS_OVERFLOW)
                      || (status == STATUS_EMPTY))
        else $error("unknown status code");

    // Final result of a request carries a zero character
    a_last_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> char_out == '0)
        else $error("final result with nonzero character");

    // Overflow and empty reports stand alone
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != STATUS_OK) |-> last)
        else $error("error status on a non-final result");

endmodule

bind string_stack_in_buffer_core ssib_checker u_ssib_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .char_out  (results.char_out),
    .last      (results.last),
    .status    (results.status)
);

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Testbench for string_stack_in_buffer_core: checks push, pop, clear and the size register.
// A scoreboard class predicts the popped characters and statuses.
// Depends on ssib_pkg, ssib_req_if, ssib_rsp_if and the core itself.
module testbench;
    import ssib_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int MAX_REPORTS    = 10;
    localparam int SETTLE_CYCLES  = 32;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [CHAR_W-1:0]   ch;
        logic                last;
        logic [STATUS_W-1:0] status;
    } popped_char_t;

    // Track the stack contents and queue up the characters each request will return
    class stack_scoreboard;
        logic [CHAR_W-1:0] store [BUF_BYTES];
        int unsigned       top;
        int unsigned       newest;
        bit                has_entries;
        int unsigned       pend_len;
        bit                pend_ovf;
        int unsigned       size_reg;
        popped_char_t      expected_chars [$];
        int                mismatches;
        int                checked;
        int                requests_seen;
        int                pops;
        int                rejected;
        int                empty_pops;

        function new();
            size_reg = SIZE_RESET;
            empty_stack();
        endfunction

        function void empty_stack();
            top         = 0;
            newest      = 0;
            has_entries = 1'b0;
            pend_len    = 0;
            pend_ovf    = 1'b0;
        endfunction

        function void resize(int unsigned value);
            size_reg = value;
            empty_stack();
        endfunction

        function int outstanding();
            return expected_chars.size();
        endfunction

        function void expect_char(logic [CHAR_W-1:0] ch, logic last,
                                  logic [STATUS_W-1:0] status);
            popped_char_t item;
            item.ch     = ch;
            item.last   = last;
            item.status = status;
            expected_chars.push_back(item);
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch);
            int unsigned lim;
            int unsigned pos;
            int unsigned need;
            int unsigned start;
            int unsigned len;
            int unsigned link;
            int unsigned i;
            lim = (size_reg < BUF_BYTES) ? size_reg : BUF_BYTES;
            requests_seen++;
            case (cmd)
                CMD_PUSH:
                begin
                    if (ch != 8'h00)
                    begin
                        // Store the character; past the length limit only flag it
                        if (pend_len >= MAX_LEN)
                        begin
                            pend_ovf = 1'b1;
                        end
                        else
                        begin
                            pos = top + pend_len;
                            if (pos < lim)
                                store[pos] = ch;
                            pend_len++;
                        end
                    end
                    else
                    begin
                        // Commit the record if it fits, else roll it back
                        need = top + pend_len + 1 + LINK_BYTES;
                        if (!pend_ovf && need <= lim)
                        begin
                            pos = top + pend_len;
                            store[pos] = 8'h00;
                            for (i = 0; i < LINK_BYTES; i++)
                                store[pos + 1 + i] = 8'(newest >> (8 * i));
                            newest      = top;
                            has_entries = 1'b1;
                            top         = need;
                            expect_char(8'h00, 1'b1, STATUS_OK);
                        end
                        else
                        begin
                            rejected++;
                            expect_char(8'h00, 1'b1, STATUS_OVERFLOW);
                        end
                        pend_len = 0;
                        pend_ovf = 1'b0;
                    end
                end
                CMD_POP:
                begin
                    pend_len = 0;
                    pend_ovf = 1'b0;
                    if (!has_entries)
                    begin
                        empty_pops++;
                        expect_char(8'h00, 1'b1, STATUS_EMPTY);
                    end
                    else
                    begin
                        // Emit the newest record, then restore the previous start
                        pops++;
                        start = newest;
                        len   = 0;
                        while (len < MAX_LEN && store[start + len] != 8'h00)
                        begin
                            expect_char(store[start + len], 1'b0, STATUS_OK);
                            len++;
                        end
                        expect_char(8'h00, 1'b1, STATUS_OK);
                        link = 0;
                        for (i = 0; i < LINK_BYTES; i++)
                            link = link | (32'(store[start + len + 1 + i]) << (8 * i));
                        top         = start;
                        newest      = link % BUF_BYTES;
                        has_entries = (start != 0);
                        if (!has_entries)
                            newest = 0;
                    end
                end
                CMD_CLEAR:
                begin
                    empty_stack();
                end
                default:
                begin
                    requests_seen--;
                end
            endcase
        endfunction

        function void check_result(logic [CHAR_W-1:0] ch, logic last,
                                   logic [STATUS_W-1:0] status);
            popped_char_t want;
            checked++;
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("ERROR: unexpected result char_out=%h last=%b status=%0d",
                             ch, last, status);
                return;
            end
            want = expected_chars.pop_front();
            if (want.ch !== ch || want.last !== last || want.status !== status)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"ERROR: result %0d expected char_out=%h last=%b status=%0d,",
                              " got char_out=%h last=%b status=%0d"},
                             checked, want.ch, want.last, want.status, ch, last, status);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic buffer_size_we;
    logic [SIZE_W-1:0] buffer_size;

    ssib_req_if requests ();
    ssib_rsp_if results ();

    stack_scoreboard sb;
    int items_sent;
    int quiet_cycles;
    bit calm;
    bit hold_off_go;

    string_stack_in_buffer_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .requests       (requests),
        .results        (results),
        .buffer_size_we (buffer_size_we),
        .buffer_size    (buffer_size)
    );

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Drive result ready: random stalls, one long hold-off on request
    initial
    begin
        int stall_left;
        stall_left    = 0;
        results.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_go)
            begin
                results.ready <= 1'b0;
                hold_off_go = 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                results.ready <= 1'b0;
                stall_left--;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 13) - 1;
                results.ready <= 1'b0;
            end
            else
            begin
                results.ready <= 1'b1;
            end
        end
    end

    // Check results, note accepted requests, watch for a stuck block
    always @(posedge clk)
    begin
        bit moved;
        moved = 1'b0;
        if (results.valid === 1'b1 && results.ready === 1'b1)
        begin
            sb.check_result(results.char_out, results.last, results.status);
            moved = 1'b1;
        end
        if (requests.valid === 1'b1 && requests.ready === 1'b1)
        begin
            sb.note_request(requests.cmd, requests.char_in);
            moved = 1'b1;
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL string_stack_in_buffer_core");
            $finish;
        end
    end

    // Offer one request, with an occasional idle burst ahead of it
    task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            requests.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        requests.valid   <= 1'b1;
        requests.cmd     <= cmd;
        requests.char_in <= ch;
        @(posedge clk);
        while (requests.ready !== 1'b1) @(posedge clk);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    // Push random nonzero characters, optionally followed by the terminator
    task automatic push_string(input int len, input bit terminate);
        int k;
        for (k = 0; k < len; k++)
            send_request(CMD_PUSH, 8'($urandom_range(1, 255)));
        if (terminate)
            send_request(CMD_PUSH, 8'h00);
    endtask

    // Hold off new requests until every expected character is back
    task automatic wait_drained();
        requests.valid <= 1'b0;
        @(posedge clk);
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input int unsigned value);
        buffer_size_we <= 1'b1;
        buffer_size    <= SIZE_W'(value);
        @(posedge clk);
        sb.resize(value & 32'h1FFF);
        buffer_size_we <= 1'b0;
    endtask

    // Mostly whole strings and pops, with broken strings, clears and unused codes
    task automatic run_random(input int n_items, input bit long_first);
        int target;
        int pick;
        target = items_sent + n_items;
        if (long_first)
        begin
            push_string(MAX_LEN, 1'b1);
            push_string(MAX_LEN + 1, 1'b1);
            send_request(CMD_POP, 8'($urandom_range(0, 255)));
        end
        while (items_sent < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                if ($urandom_range(0, 15) == 0)
                    push_string($urandom_range(MAX_LEN - 2, MAX_LEN + 3), 1'b1);
                else
                    push_string($urandom_range(0, 10), 1'b1);
            end
            else if (pick < 55)
            begin
                push_string($urandom_range(1, 6), 1'b0);
                send_request($urandom_range(0, 1) ? CMD_POP : CMD_CLEAR,
                             8'($urandom_range(0, 255)));
            end
            else if (pick < 88)
            begin
                send_request(CMD_POP, 8'($urandom_range(0, 255)));
            end
            else if (pick < 94)
            begin
                send_request(CMD_CLEAR, 8'($urandom_range(0, 255)));
            end
            else
            begin
                send_request(CMD_UNUSED, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Stimulus
    initial
    begin
        sb               = new();
        items_sent       = 0;
        quiet_cycles     = 0;
        calm             = 1'b0;
        hold_off_go      = 1'b0;
        rst_n            = 1'b0;
        buffer_size_we   = 1'b0;
        buffer_size      = SIZE_RESET;
        requests.valid   = 1'b0;
        requests.cmd     = CMD_PUSH;
        requests.char_in = 8'h00;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty pop, empty string, extreme characters, unused code, dropped strings
        send_request(CMD_POP, 8'hFF);
        send_request(CMD_PUSH, 8'h00);
        send_request(CMD_PUSH, 8'h01);
        send_request(CMD_PUSH, 8'h80);
        send_request(CMD_PUSH, 8'h7F);
        send_request(CMD_PUSH, 8'hFF);
        send_request(CMD_PUSH, 8'h00);
        send_request(CMD_POP, 8'h00);
        send_request(CMD_POP, 8'h00);
        send_request(CMD_POP, 8'h00);
        send_request(CMD_UNUSED, 8'h55);
        send_request(CMD_PUSH, 8'h41);
        send_request(CMD_PUSH, 8'h42);
        send_request(CMD_CLEAR, 8'hAA);
        send_request(CMD_PUSH, 8'h43);
        send_request(CMD_POP, 8'h00);
        wait_drained();

        // Zero size: every push is rejected
        write_size(0);
        send_request(CMD_PUSH, 8'h5A);
        send_request(CMD_PUSH, 8'h00);
        send_request(CMD_POP, 8'h00);
        wait_drained();

        // Size of exactly one empty record
        write_size(3);
        send_request(CMD_PUSH, 8'h00);
        send_request(CMD_PUSH, 8'h00);
        send_request(CMD_POP, 8'h00);
        send_request(CMD_POP, 8'h00);
        wait_drained();

        // Largest register value, strings at the length limit
        write_size(13'h1FFF);
        run_random(130, 1'b1);
        wait_drained();

        // Tight store with a long result stall while requests keep coming
        write_size($urandom_range(24, 160));
        hold_off_go = 1'b1;
        run_random(20, 1'b0);
        wait_drained();

        write_size(BUF_BYTES - 1);
        run_random(8, 1'b0);
        wait_drained();

        // Final stretch with no idling on either side
        calm = 1'b1;
        write_size($urandom_range(32, 300));
        run_random(8, 1'b0);
        wait_drained();

        $display("Covered %0d requests and %0d result characters over seven size settings",
                 sb.requests_seen, sb.checked);
        $display("  %0d pops of stored strings, %0d pops of an empty stack, %0d rejected pushes",
                 sb.pops, sb.empty_pops, sb.rejected);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
        begin
            $display("PASS string_stack_in_buffer_core");
        end
        else
        begin
            $display("ERROR: %0d mismatches, %0d results never arrived",
                     sb.mismatches, sb.outstanding());
            $display("FAIL string_stack_in_buffer_core");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/ssib_pkg.sv
hdl/ssib_req_if.sv
hdl/ssib_rsp_if.sv
hdl/ssib_ram.sv
hdl/ssib_front.sv
hdl/ssib_back.sv
hdl/string_stack_in_buffer_core.sv
hdl/ssib_checker.sv
dv/testbench.sv
